[rtl/cau_pkg.sv]
// ----------------------------------------------------------------------------
// cau_pkg
// Shared widths, action codes, result records, saturation helpers and the
// arctangent table of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

	localparam int PART_W       = 16;
	localparam int FRAC_W       = 8;
	localparam int TOL_W        = 15;
	localparam int PROD_W       = 2 * PART_W;
	localparam int SUM_W        = PROD_W + 1;
	localparam int CLIP_W       = SUM_W + 1;
	localparam int QUO_W        = PART_W + 1;
	localparam int CORDIC_STEPS = 32;
	localparam int XY_W         = 64;
	localparam int XY_SHIFT     = 61 - PART_W;
	localparam int Z_W          = 36;
	localparam int ANG_FRAC     = 30;
	localparam int DR_LAT       = QUO_W + 2;
	localparam int CORDIC_LAT   = CORDIC_STEPS + 2;

	localparam logic [TOL_W-1:0] TOL_RESET = 15'd1;
	localparam logic signed [Z_W-1:0] PI_Q30 = 36'sd3373259426;

	typedef enum logic [2:0] {
		ACT_ADD,
		ACT_SUB,
		ACT_MUL,
		ACT_DIV,
		ACT_CONJ,
		ACT_MAG,
		ACT_ANGLE,
		ACT_EQUAL
	} action_t;

	typedef struct packed {
		logic [PART_W-1:0] part;
		logic              sat;
	} part_sat_t;

	typedef struct packed {
		logic [PART_W-1:0] re;
		logic [PART_W-1:0] im;
		logic              eq;
		logic              dz;
		logic              sat;
	} res_t;

	typedef struct packed {
		part_sat_t quo_re;
		part_sat_t quo_im;
		logic      dz;
		part_sat_t root;
	} dr_res_t;

	function automatic part_sat_t clip_part(input logic neg, input logic [CLIP_W-1:0] mag);
		part_sat_t         r;
		logic [CLIP_W-1:0] maxp;
		logic [CLIP_W-1:0] negv;
		maxp = {{(CLIP_W-PART_W+1){1'b0}}, {(PART_W-1){1'b1}}};
		negv = -mag;
		r.sat = 1'b0;
		if (!neg) begin
			if (mag > maxp) begin
				r.part = maxp[PART_W-1:0];
				r.sat  = 1'b1;
			end else begin
				r.part = mag[PART_W-1:0];
			end
		end else begin
			if (mag > maxp + 1'b1) begin
				r.part = {1'b1, {(PART_W-1){1'b0}}};
				r.sat  = 1'b1;
			end else begin
				r.part = negv[PART_W-1:0];
			end
		end
		return r;
	endfunction

	function automatic logic [CLIP_W-1:0] abs_ext(input logic signed [CLIP_W-1:0] x);
		return x[CLIP_W-1] ? -x : x;
	endfunction

	function automatic part_sat_t clip_signed(input logic signed [CLIP_W-1:0] x);
		return clip_part(x[CLIP_W-1], abs_ext(x));
	endfunction

	function automatic logic [ANG_FRAC-1:0] atan_q30(input logic [4:0] idx);
		logic [ANG_FRAC-1:0] v;
		case (idx)
			5'd0:  v = 30'd843314857;
			5'd1:  v = 30'd497837829;
			5'd2:  v = 30'd263043837;
			5'd3:  v = 30'd133525159;
			5'd4:  v = 30'd67021687;
			5'd5:  v = 30'd33543516;
			5'd6:  v = 30'd16775851;
			5'd7:  v = 30'd8388437;
			5'd8:  v = 30'd4194283;
			5'd9:  v = 30'd2097149;
			5'd10: v = 30'd1048576;
			5'd11: v = 30'd524288;
			5'd12: v = 30'd262144;
			5'd13: v = 30'd131072;
			5'd14: v = 30'd65536;
			5'd15: v = 30'd32768;
			5'd16: v = 30'd16384;
			5'd17: v = 30'd8192;
			5'd18: v = 30'd4096;
			5'd19: v = 30'd2048;
			5'd20: v = 30'd1024;
			5'd21: v = 30'd512;
			5'd22: v = 30'd256;
			5'd23: v = 30'd128;
			5'd24: v = 30'd64;
			5'd25: v = 30'd32;
			5'd26: v = 30'd16;
			5'd27: v = 30'd8;
			5'd28: v = 30'd4;
			5'd29: v = 30'd2;
			5'd30: v = 30'd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

[rtl/complex_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex add, subtract, multiply, divide, conjugate, magnitude, angle and
// compare on signed Q8.8 parts, with rounding and saturation.
//
//   channel   direction  payload (low bits first)
//   s_axis    in         tdata: a_re, a_im, b_re, b_im   tuser: action
//   m_axis    out        tdata: res_re, res_im   tuser: is_equal, div_zero, saturated
//   cfg       in         cfg_wdata: equal_tolerance, written when cfg_we
//
// One transfer in and one out per cycle while the output is not stalled; a
// result passes through the operand stage, the CORDIC entry stage, its 32
// rotation stages, its rounding stage and the output register.
// Divider and root run as 17 and 16 stages beside it and are delayed to match.
// A stalled output holds every stage; nothing is dropped or repeated.
// Reset clears all valid bits and sets the tolerance to 1.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [4*cau_pkg::PART_W-1:0]      s_axis_tdata,  // a_re, a_im, b_re, b_im
	input  logic [2:0]                        s_axis_tuser,  // action
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [2*cau_pkg::PART_W-1:0]      m_axis_tdata,  // res_re, res_im
	output logic [2:0]                        m_axis_tuser,  // is_equal, div_zero, saturated
	input  logic                              cfg_we,
	input  logic [cau_pkg::TOL_W-1:0]         cfg_wdata
);

	localparam int PW     = cau_pkg::PART_W;
	localparam int PRW    = cau_pkg::PROD_W;
	localparam int SW     = cau_pkg::SUM_W;
	localparam int CW     = cau_pkg::CLIP_W;
	localparam int FW     = cau_pkg::FRAC_W;
	localparam int DR_OUT = 3 + cau_pkg::DR_LAT;
	localparam int CO_OUT = 1 + cau_pkg::CORDIC_LAT;
	localparam int NS     = CO_OUT + 1;

	logic [NS:1]              vld_s;
	cau_pkg::action_t         act_s [1:NS-1];
	logic [cau_pkg::TOL_W-1:0] tol_q;
	logic                     adv;

	logic signed [PW-1:0]  ar_s1, ai_s1, br_s1, bi_s1;
	logic signed [PRW-1:0] p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2;
	logic signed [PRW-1:0] sb_re_s2, sb_im_s2, sa_re_s2, sa_im_s2;
	cau_pkg::res_t         early_s2, early_s3;
	logic signed [SW-1:0]  mre_s3, mim_s3, nre_s3, nim_s3;
	logic [PRW-1:0]        den_s3, sq_s3;
	cau_pkg::res_t         res_s [4:NS];

	logic signed [PW:0]    sum_re, sum_im, dif_re, dif_im;
	cau_pkg::part_sat_t    ps_re, ps_im, pm_re, pm_im;
	cau_pkg::res_t         early, res4, dr_sel, co_sel;
	logic [CW-1:0]         mm_re, mm_im;
	cau_pkg::dr_res_t      dr;
	cau_pkg::part_sat_t    ang;

	assign adv           = !vld_s[NS] || m_axis_tready;
	assign s_axis_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			tol_q <= cau_pkg::TOL_RESET;
		end else begin
			if (adv) begin
				vld_s <= {vld_s[NS-1:1], s_axis_tvalid};
			end
			if (cfg_we) begin
				tol_q <= cfg_wdata;
			end
		end
	end

	always_comb begin
		sum_re = (PW+1)'(ar_s1) + (PW+1)'(br_s1);
		sum_im = (PW+1)'(ai_s1) + (PW+1)'(bi_s1);
		dif_re = (PW+1)'(ar_s1) - (PW+1)'(br_s1);
		dif_im = (PW+1)'(ai_s1) - (PW+1)'(bi_s1);
		ps_re  = '0;
		ps_im  = '0;
		early  = '0;
		case (act_s[1])
			cau_pkg::ACT_ADD: begin
				ps_re = cau_pkg::clip_signed(CW'(sum_re));
				ps_im = cau_pkg::clip_signed(CW'(sum_im));
				early.re  = ps_re.part;
				early.im  = ps_im.part;
				early.sat = ps_re.sat | ps_im.sat;
			end
			cau_pkg::ACT_SUB: begin
				ps_re = cau_pkg::clip_signed(CW'(dif_re));
				ps_im = cau_pkg::clip_signed(CW'(dif_im));
				early.re  = ps_re.part;
				early.im  = ps_im.part;
				early.sat = ps_re.sat | ps_im.sat;
			end
			cau_pkg::ACT_CONJ: begin
				ps_im = cau_pkg::clip_signed(-CW'(ai_s1));
				early.re  = ar_s1;
				early.im  = ps_im.part;
				early.sat = ps_im.sat;
			end
			cau_pkg::ACT_EQUAL: begin
				early.eq = (cau_pkg::abs_ext(CW'(dif_re)) < CW'(tol_q)) &&
					(cau_pkg::abs_ext(CW'(dif_im)) < CW'(tol_q));
			end
			default: begin
				early = '0;
			end
		endcase
	end

	always_comb begin
		mm_re = (cau_pkg::abs_ext(CW'(mre_s3)) + CW'(1 << (FW - 1))) >> FW;
		mm_im = (cau_pkg::abs_ext(CW'(mim_s3)) + CW'(1 << (FW - 1))) >> FW;
		pm_re = cau_pkg::clip_part(mre_s3[SW-1], mm_re);
		pm_im = cau_pkg::clip_part(mim_s3[SW-1], mm_im);
		if (act_s[3] == cau_pkg::ACT_MUL) begin
			res4     = '0;
			res4.re  = pm_re.part;
			res4.im  = pm_im.part;
			res4.sat = pm_re.sat | pm_im.sat;
		end else begin
			res4 = early_s3;
		end
	end

	always_comb begin
		dr_sel = res_s[DR_OUT];
		if (act_s[DR_OUT] == cau_pkg::ACT_DIV) begin
			dr_sel     = '0;
			dr_sel.re  = dr.quo_re.part;
			dr_sel.im  = dr.quo_im.part;
			dr_sel.dz  = dr.dz;
			dr_sel.sat = dr.quo_re.sat | dr.quo_im.sat;
		end else if (act_s[DR_OUT] == cau_pkg::ACT_MAG) begin
			dr_sel     = '0;
			dr_sel.re  = dr.root.part;
			dr_sel.sat = dr.root.sat;
		end
		co_sel = res_s[NS-1];
		if (act_s[NS-1] == cau_pkg::ACT_ANGLE) begin
			co_sel     = '0;
			co_sel.re  = ang.part;
			co_sel.sat = ang.sat;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s[1] <= cau_pkg::action_t'(s_axis_tuser);
			for (int k = 2; k <= NS - 1; k++) begin
				act_s[k] <= act_s[k-1];
			end
			ar_s1 <= s_axis_tdata[PW-1:0];
			ai_s1 <= s_axis_tdata[2*PW-1:PW];
			br_s1 <= s_axis_tdata[3*PW-1:2*PW];
			bi_s1 <= s_axis_tdata[4*PW-1:3*PW];

			p_rr_s2  <= ar_s1 * br_s1;
			p_ii_s2  <= ai_s1 * bi_s1;
			p_ri_s2  <= ar_s1 * bi_s1;
			p_ir_s2  <= ai_s1 * br_s1;
			sa_re_s2 <= ar_s1 * ar_s1;
			sa_im_s2 <= ai_s1 * ai_s1;
			sb_re_s2 <= br_s1 * br_s1;
			sb_im_s2 <= bi_s1 * bi_s1;
			early_s2 <= early;

			mre_s3   <= SW'(p_rr_s2) - SW'(p_ii_s2);
			mim_s3   <= SW'(p_ri_s2) + SW'(p_ir_s2);
			nre_s3   <= SW'(p_rr_s2) + SW'(p_ii_s2);
			nim_s3   <= SW'(p_ir_s2) - SW'(p_ri_s2);
			den_s3   <= $unsigned(sb_re_s2) + $unsigned(sb_im_s2);
			sq_s3    <= $unsigned(sa_re_s2) + $unsigned(sa_im_s2);
			early_s3 <= early_s2;

			res_s[4] <= res4;
			for (int k = 5; k <= DR_OUT; k++) begin
				res_s[k] <= res_s[k-1];
			end
			res_s[DR_OUT+1] <= dr_sel;
			for (int k = DR_OUT + 2; k <= NS - 1; k++) begin
				res_s[k] <= res_s[k-1];
			end
			res_s[NS] <= co_sel;
		end
	end

	cau_divroot u_divroot (
		.clk (clk),
		.adv (adv),
		.nre (nre_s3),
		.nim (nim_s3),
		.den (den_s3),
		.sq  (sq_s3),
		.res (dr)
	);

	cau_cordic u_cordic (
		.clk   (clk),
		.adv   (adv),
		.re    (ar_s1),
		.im    (ai_s1),
		.angle (ang)
	);

	assign m_axis_tvalid = vld_s[NS];
	assign m_axis_tdata  = {res_s[NS].im, res_s[NS].re};
	assign m_axis_tuser  = {res_s[NS].sat, res_s[NS].dz, res_s[NS].eq};

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NS] |-> $onehot0({res_s[NS].eq, res_s[NS].dz, res_s[NS].sat}))
		else $error("result flags overlap");

	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[NS] && (res_s[NS].eq || res_s[NS].dz)) |->
		(res_s[NS].re == '0 && res_s[NS].im == '0))
		else $error("flagged result carries nonzero parts");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s))
		else $error("pipeline moved during stall");

	a_accept_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> vld_s[1])
		else $error("accepted transfer missing from first stage");

endmodule

[rtl/cau_divroot.sv]
// ----------------------------------------------------------------------------
// cau_divroot
// Pipelined restoring divider for both quotient parts and pipelined
// digit-by-digit square root, one quotient bit or root bit per stage.
// ----------------------------------------------------------------------------
module cau_divroot (
	input  logic                              clk,
	input  logic                              adv,
	input  logic signed [cau_pkg::SUM_W-1:0]  nre,
	input  logic signed [cau_pkg::SUM_W-1:0]  nim,
	input  logic        [cau_pkg::PROD_W-1:0] den,
	input  logic        [cau_pkg::PROD_W-1:0] sq,
	output cau_pkg::dr_res_t                  res
);

	localparam int PRW = cau_pkg::PROD_W;
	localparam int SW  = cau_pkg::SUM_W;
	localparam int CW  = cau_pkg::CLIP_W;
	localparam int QW  = cau_pkg::QUO_W;
	localparam int PW  = cau_pkg::PART_W;
	localparam int RS  = QW - cau_pkg::FRAC_W - 1;

	typedef struct packed {
		logic           neg;
		logic           big;
		logic [PRW-1:0] rem;
		logic [RS-1:0]  lo;
		logic [QW-1:0]  q;
	} dv_t;

	dv_t            dv_s  [0:1][0:QW];
	logic [PRW-1:0] den_s [0:QW];
	logic           dz_s  [0:QW];
	logic [PRW-1:0] sn_s  [0:QW];
	logic [PRW-1:0] sr_s  [0:QW];
	dv_t            dv_init [0:1];

	function automatic dv_t div_step(input dv_t d, input logic [PRW-1:0] dv);
		dv_t          o;
		logic [PRW:0] r2;
		logic [PRW:0] df;
		o  = d;
		r2 = {d.rem, d.lo[RS-1]};
		df = r2 - {1'b0, dv};
		o.lo = d.lo << 1;
		if (r2 >= {1'b0, dv}) begin
			o.rem = df[PRW-1:0];
			o.q   = {d.q[QW-2:0], 1'b1};
		end else begin
			o.rem = r2[PRW-1:0];
			o.q   = {d.q[QW-2:0], 1'b0};
		end
		return o;
	endfunction

	function automatic dv_t div_init(input logic signed [SW-1:0] n, input logic [PRW-1:0] dv);
		dv_t            o;
		logic [SW-1:0]  m;
		logic [PRW-1:0] num;
		m     = n[SW-1] ? -n : n;
		num   = m[PRW-1:0];
		o.neg = n[SW-1];
		o.big = {{RS{1'b0}}, num} >= {dv, {RS{1'b0}}};
		o.rem = num >> RS;
		o.lo  = num[RS-1:0];
		o.q   = '0;
		return o;
	endfunction

	function automatic cau_pkg::part_sat_t div_final(input dv_t d, input logic dz);
		cau_pkg::part_sat_t r;
		logic [QW:0]        qv;
		qv = ({1'b0, d.q} + 1'b1) >> 1;
		if (dz) begin
			r = '0;
		end else if (d.big) begin
			r = cau_pkg::clip_part(d.neg, {CW{1'b1}});
		end else begin
			r = cau_pkg::clip_part(d.neg, CW'(qv));
		end
		return r;
	endfunction

	always_comb begin
		dv_init[0] = div_init(nre, den);
		dv_init[1] = div_init(nim, den);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_s[0][0] <= dv_init[0];
			dv_s[1][0] <= dv_init[1];
			den_s[0]   <= den;
			dz_s[0]    <= (den == '0);
			sn_s[0]    <= sq;
			sr_s[0]    <= '0;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [PRW-1:0] bitv;
		logic [PRW-1:0] trial;
		assign bitv  = (k < PW) ? (PRW'(1) << (PRW - 2 - 2 * k)) : '0;
		assign trial = sr_s[k] + bitv;
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[0][k+1] <= div_step(dv_s[0][k], den_s[k]);
				dv_s[1][k+1] <= div_step(dv_s[1][k], den_s[k]);
				den_s[k+1]   <= den_s[k];
				dz_s[k+1]    <= dz_s[k];
				if (k >= PW) begin
					sn_s[k+1] <= sn_s[k];
					sr_s[k+1] <= sr_s[k];
				end else if (sn_s[k] >= trial) begin
					sn_s[k+1] <= sn_s[k] - trial;
					sr_s[k+1] <= (sr_s[k] >> 1) + bitv;
				end else begin
					sn_s[k+1] <= sn_s[k];
					sr_s[k+1] <= sr_s[k] >> 1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res.quo_re <= div_final(dv_s[0][QW], dz_s[QW]);
			res.quo_im <= div_final(dv_s[1][QW], dz_s[QW]);
			res.dz     <= dz_s[QW];
			res.root   <= cau_pkg::clip_part(1'b0,
				CW'(sr_s[QW]) + CW'(sn_s[QW] > sr_s[QW]));
		end
	end

endmodule

[rtl/cau_cordic.sv]
// ----------------------------------------------------------------------------
// cau_cordic
// Pipelined vectoring CORDIC, one rotation per stage, giving the angle of a
// complex value rounded to the part format.
// ----------------------------------------------------------------------------
module cau_cordic (
	input  logic                              clk,
	input  logic                              adv,
	input  logic signed [cau_pkg::PART_W-1:0] re,
	input  logic signed [cau_pkg::PART_W-1:0] im,
	output cau_pkg::part_sat_t                angle
);

	localparam int XW = cau_pkg::XY_W;
	localparam int ZW = cau_pkg::Z_W;
	localparam int CW = cau_pkg::CLIP_W;
	localparam int NI = cau_pkg::CORDIC_STEPS;
	localparam int RSH = cau_pkg::ANG_FRAC - cau_pkg::FRAC_W;

	logic signed [XW-1:0] x_s  [0:NI];
	logic signed [XW-1:0] y_s  [0:NI];
	logic signed [ZW-1:0] z_s  [0:NI];
	logic                 sp_s [0:NI];
	logic                 spn_s[0:NI];

	logic signed [XW-1:0] xe, ye, x0, y0;
	logic signed [ZW-1:0] z0, zf;
	logic [ZW-1:0]        zm, zr;

	always_comb begin
		xe = XW'(re) <<< cau_pkg::XY_SHIFT;
		ye = XW'(im) <<< cau_pkg::XY_SHIFT;
		x0 = xe;
		y0 = ye;
		z0 = '0;
		if (re < 0) begin
			z0 = (im > 0) ? cau_pkg::PI_Q30 : -cau_pkg::PI_Q30;
			x0 = -xe;
			y0 = -ye;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s[0]   <= x0;
			y_s[0]   <= y0;
			z_s[0]   <= z0;
			sp_s[0]  <= (im == '0);
			spn_s[0] <= (re < 0);
		end
	end

	for (genvar i = 0; i < NI; i++) begin : g_rot
		logic signed [XW-1:0] xs, ys;
		logic signed [ZW-1:0] at;
		assign xs = x_s[i] >>> i;
		assign ys = y_s[i] >>> i;
		assign at = ZW'(cau_pkg::atan_q30(5'(i)));
		always_ff @(posedge clk) begin
			if (adv) begin
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + ys;
					y_s[i+1] <= y_s[i] - xs;
					z_s[i+1] <= z_s[i] + at;
				end else begin
					x_s[i+1] <= x_s[i] - ys;
					y_s[i+1] <= y_s[i] + xs;
					z_s[i+1] <= z_s[i] - at;
				end
				sp_s[i+1]  <= sp_s[i];
				spn_s[i+1] <= spn_s[i];
			end
		end
	end

	always_comb begin
		if (sp_s[NI]) begin
			zf = spn_s[NI] ? cau_pkg::PI_Q30 : '0;
		end else begin
			zf = z_s[NI];
		end
		zm = zf[ZW-1] ? -zf : zf;
		zr = (zm + (ZW'(1) << (RSH - 1))) >> RSH;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			angle <= cau_pkg::clip_part(zf[ZW-1], CW'(zr));
		end
	end

endmodule
